>>> rtl/core/swfr_pkg.sv
// ----------------------------------------------------------------------------
// swfr_pkg
// Shared types, codes and the CRC-16-CCITT byte update for the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package swfr_pkg;

  localparam int unsigned MAX_PACKET_LEN_DEF = 512;
  localparam int unsigned QUEUE_DEPTH        = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // verdict codes
  localparam logic [2:0] VERDICT_ACCEPTED  = 3'd0;
  localparam logic [2:0] VERDICT_OUT_ORDER = 3'd1;
  localparam logic [2:0] VERDICT_RESET     = 3'd2;
  localparam logic [2:0] VERDICT_DROPPED   = 3'd3;
  localparam logic [2:0] VERDICT_IGNORED   = 3'd4;

  // item kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // register indexes
  localparam logic [2:0] REG_LINK_ACTIVE = 3'd0;
  localparam logic [2:0] REG_DATA_TYPE   = 3'd1;
  localparam logic [2:0] REG_RESET_TYPE  = 3'd2;
  localparam logic [2:0] REG_ACK_TYPE    = 3'd3;
  localparam logic [2:0] REG_ACK_WINDOW  = 3'd4;

  typedef struct packed {
    logic        link_active;
    logic [7:0]  data_type_code;
    logic [7:0]  reset_type_code;
    logic [7:0]  ack_window;
    logic [15:0] ack_crc_seed;   // CRC of the ack type byte
  } cfg_t;

  // one queue entry: a payload byte or a verdict with partial ack CRC
  typedef struct packed {
    logic        kind;
    logic [7:0]  data;       // payload byte or ack seq
    logic [2:0]  verdict;
    logic        ack;
    logic [15:0] part_crc;   // CRC over ack type and seq
  } entry_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sliding_window_frame_receiver.sv
// Throughput: one input beat per cycle unless the queue is full; the parser
// updates the frame CRC one byte per cycle and a 4-entry queue decouples it
// from the output register. A result is registered in the queue, then in the
// output register. Reset: synchronous active-low rst_n clears the parser,
// queue and output valid and restores register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// sliding_window_frame_receiver
// Sequenced frame receiver with CRC-16 check and acknowledgement generation.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_frame_receiver #(
  parameter int unsigned MAX_PACKET_LEN = swfr_pkg::MAX_PACKET_LEN_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_data_byte,
  input  wire logic         in_last_of_packet,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              out_item_kind,
  output logic [7:0]        out_payload_byte,
  output logic [2:0]        out_verdict,
  output logic              out_ack_valid,
  output logic [7:0]        out_ack_seq,
  output logic [7:0]        out_ack_window_out,
  output logic [15:0]       out_ack_crc
);
  import swfr_pkg::*;

  cfg_t   cfg;
  logic   push;
  entry_t push_entry;
  logic   full;
  logic   empty;
  logic   pop;
  entry_t head;

  assign in_ready = !full;

  swfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swfr_front #(
    .MAX_PACKET_LEN (MAX_PACKET_LEN)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_last_of_packet (in_last_of_packet),
    .push              (push),
    .push_entry        (push_entry)
  );

  swfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .head       (head)
  );

  swfr_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .empty              (empty),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_item_kind      (out_item_kind),
    .out_payload_byte   (out_payload_byte),
    .out_verdict        (out_verdict),
    .out_ack_valid      (out_ack_valid),
    .out_ack_seq        (out_ack_seq),
    .out_ack_window_out (out_ack_window_out),
    .out_ack_crc        (out_ack_crc)
  );

endmodule

`default_nettype wire

>>> rtl/core/swfr_cfg.sv
// ----------------------------------------------------------------------------
// swfr_cfg
// APB register file holding the link, frame type and ack settings.
// ----------------------------------------------------------------------------
`default_nettype none

module swfr_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output swfr_pkg::cfg_t    cfg
);
  import swfr_pkg::*;

  logic        link_active_r;
  logic [7:0]  data_type_r;
  logic [7:0]  reset_type_r;
  logic [7:0]  ack_type_r;
  logic [7:0]  ack_window_r;
  logic [15:0] ack_seed_r;
  logic        wr_en;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_active_r <= 1'b0;
      data_type_r   <= 8'd1;
      reset_type_r  <= 8'd3;
      ack_type_r    <= 8'd2;
      ack_window_r  <= 8'd8;
    end else if (wr_en) begin
      unique case (idx)
        REG_LINK_ACTIVE: link_active_r <= pwdata[0];
        REG_DATA_TYPE:   data_type_r   <= pwdata[7:0];
        REG_RESET_TYPE:  reset_type_r  <= pwdata[7:0];
        REG_ACK_TYPE:    ack_type_r    <= pwdata[7:0];
        REG_ACK_WINDOW:  ack_window_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // first byte of the ack CRC only moves with the ack type register
  always_ff @(posedge clk) begin
    ack_seed_r <= crc16_byte(CRC_INIT, ack_type_r);
  end

  always_comb begin
    unique case (idx)
      REG_LINK_ACTIVE: prdata = {31'd0, link_active_r};
      REG_DATA_TYPE:   prdata = {24'd0, data_type_r};
      REG_RESET_TYPE:  prdata = {24'd0, reset_type_r};
      REG_ACK_TYPE:    prdata = {24'd0, ack_type_r};
      REG_ACK_WINDOW:  prdata = {24'd0, ack_window_r};
      default:         prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.link_active     = link_active_r;
    cfg.data_type_code  = data_type_r;
    cfg.reset_type_code = reset_type_r;
    cfg.ack_window      = ack_window_r;
    cfg.ack_crc_seed    = ack_seed_r;
  end

endmodule

`default_nettype wire

>>> rtl/core/swfr_front.sv
// ----------------------------------------------------------------------------
// swfr_front
// Frame parser: tracks header fields and CRC per byte, classifies each beat.
// ----------------------------------------------------------------------------
`default_nettype none

module swfr_front #(
  parameter int unsigned MAX_PACKET_LEN = swfr_pkg::MAX_PACKET_LEN_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire swfr_pkg::cfg_t  cfg,
  input  wire logic            in_valid,
  input  wire logic            in_ready,
  input  wire logic [7:0]      in_data_byte,
  input  wire logic            in_last_of_packet,
  output logic                 push,
  output swfr_pkg::entry_t     push_entry
);
  import swfr_pkg::*;

  localparam logic [16:0] MAX_LEN = 17'(MAX_PACKET_LEN);

  logic [7:0]  exp_seq_r,  exp_seq_nxt;
  logic [15:0] pos_r,      pos_nxt;
  logic [7:0]  ftype_r,    ftype_nxt;
  logic [7:0]  fseq_r,     fseq_nxt;
  logic [15:0] plen_r,     plen_nxt;
  logic [15:0] rcrc_r,     rcrc_nxt;
  logic [15:0] tcrc_r,     tcrc_nxt;
  logic [15:0] fcrc_r,     fcrc_nxt;
  logic [15:0] recv_r,     recv_nxt;

  logic        fire;
  logic        is_reset;
  logic        is_data;
  logic        emit;
  logic [16:0] pos_ext;
  logic [16:0] crc_end;
  logic [16:0] total;
  logic        too_long;
  logic [2:0]  verdict;
  logic        ack;
  logic [7:0]  ack_seq;

  assign fire    = in_valid && in_ready;
  assign pos_ext = {1'b0, pos_r};
  assign total   = pos_ext + 17'd1;

  always_comb begin
    ftype_nxt = (pos_r == 16'd0) ? in_data_byte : ftype_r;
    fseq_nxt  = (pos_r == 16'd1) ? in_data_byte : fseq_r;
    tcrc_nxt  = (pos_r == 16'd0) ? crc16_byte(CRC_INIT, in_data_byte) : tcrc_r;
    plen_nxt  = plen_r;
    if (pos_r == 16'd2) plen_nxt = {plen_r[15:8], in_data_byte};
    if (pos_r == 16'd3) plen_nxt = {in_data_byte, plen_r[7:0]};

    is_reset = (ftype_nxt == cfg.reset_type_code);
    is_data  = !is_reset && (ftype_nxt == cfg.data_type_code);
    crc_end  = {1'b0, plen_nxt} + 17'd4;

    // reset frames carry the type-byte CRC in bytes 1 and 2
    recv_nxt = recv_r;
    if (pos_r == 16'd1 && is_reset) recv_nxt = {recv_r[15:8], in_data_byte};
    if (pos_r == 16'd2 && is_reset) recv_nxt = {in_data_byte, recv_r[7:0]};

    rcrc_nxt = rcrc_r;
    fcrc_nxt = fcrc_r;
    emit     = 1'b0;
    if (pos_r < 16'd4 || pos_ext < crc_end) begin
      rcrc_nxt = crc16_byte(rcrc_r, in_data_byte);
      emit     = (pos_r >= 16'd4) && is_data && cfg.link_active;
    end else if (pos_ext == crc_end) begin
      fcrc_nxt = rcrc_r;
      if (!is_reset) recv_nxt = {recv_r[15:8], in_data_byte};
    end else if (pos_ext == crc_end + 17'd1) begin
      if (!is_reset) recv_nxt = {in_data_byte, recv_r[7:0]};
    end
    // zero-length payload: CRC ends with the header
    if (pos_r == 16'd3 && crc_end == 17'd4) fcrc_nxt = rcrc_nxt;

    // packet-end verdict
    too_long = total > MAX_LEN;
    verdict  = VERDICT_IGNORED;
    ack      = 1'b0;
    ack_seq  = 8'd0;
    exp_seq_nxt = exp_seq_r;
    if (!cfg.link_active) begin
      verdict = VERDICT_IGNORED;
    end else if (is_reset) begin
      if (too_long || total < 17'd3 || recv_nxt != tcrc_nxt) begin
        verdict = VERDICT_DROPPED;
      end else begin
        verdict     = VERDICT_RESET;
        exp_seq_nxt = 8'd0;
      end
    end else if (!is_data) begin
      verdict = VERDICT_IGNORED;
    end else if (too_long || total < 17'd7 || crc_end + 17'd2 > total ||
                 recv_nxt != fcrc_nxt) begin
      verdict = VERDICT_DROPPED;
    end else if (fseq_nxt != exp_seq_r) begin
      verdict = VERDICT_OUT_ORDER;
      ack     = 1'b1;
      ack_seq = exp_seq_r - 8'd1;
    end else begin
      verdict     = VERDICT_ACCEPTED;
      ack         = 1'b1;
      ack_seq     = fseq_nxt;
      exp_seq_nxt = exp_seq_r + 8'd1;
    end

    pos_nxt = (pos_r == 16'hFFFF) ? pos_r : pos_r + 16'd1;
  end

  always_comb begin
    push = fire && (in_last_of_packet || emit);
    if (in_last_of_packet) begin
      push_entry.kind     = KIND_VERDICT;
      push_entry.data     = ack_seq;
      push_entry.verdict  = verdict;
      push_entry.ack      = ack;
      push_entry.part_crc = ack ? crc16_byte(cfg.ack_crc_seed, ack_seq) : 16'd0;
    end else begin
      push_entry.kind     = KIND_PAYLOAD;
      push_entry.data     = in_data_byte;
      push_entry.verdict  = VERDICT_ACCEPTED;
      push_entry.ack      = 1'b0;
      push_entry.part_crc = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_seq_r <= 8'd0;
      pos_r     <= 16'd0;
      ftype_r   <= 8'd0;
      fseq_r    <= 8'd0;
      plen_r    <= 16'd0;
      rcrc_r    <= CRC_INIT;
      tcrc_r    <= 16'd0;
      fcrc_r    <= 16'd0;
      recv_r    <= 16'd0;
    end else if (fire) begin
      if (in_last_of_packet) begin
        exp_seq_r <= exp_seq_nxt;
        pos_r     <= 16'd0;
        ftype_r   <= 8'd0;
        fseq_r    <= 8'd0;
        plen_r    <= 16'd0;
        rcrc_r    <= CRC_INIT;
        tcrc_r    <= 16'd0;
        fcrc_r    <= 16'd0;
        recv_r    <= 16'd0;
      end else begin
        pos_r   <= pos_nxt;
        ftype_r <= ftype_nxt;
        fseq_r  <= fseq_nxt;
        plen_r  <= plen_nxt;
        rcrc_r  <= rcrc_nxt;
        tcrc_r  <= tcrc_nxt;
        fcrc_r  <= fcrc_nxt;
        recv_r  <= recv_nxt;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/swfr_queue.sv
// ----------------------------------------------------------------------------
// swfr_queue
// Small FIFO between the parser and the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module swfr_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire swfr_pkg::entry_t  push_entry,
  output logic                   full,
  input  wire logic              pop,
  output logic                   empty,
  output swfr_pkg::entry_t       head
);
  import swfr_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  entry_t          mem [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r,    cnt_nxt;

  assign full  = (cnt_r == CW'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/swfr_back.sv
// ----------------------------------------------------------------------------
// swfr_back
// Result stage: finishes the ack CRC and holds the outgoing beat.
// ----------------------------------------------------------------------------
`default_nettype none

module swfr_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire swfr_pkg::cfg_t    cfg,
  input  wire logic              empty,
  input  wire swfr_pkg::entry_t  head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_item_kind,
  output logic [7:0]             out_payload_byte,
  output logic [2:0]             out_verdict,
  output logic                   out_ack_valid,
  output logic [7:0]             out_ack_seq,
  output logic [7:0]             out_ack_window_out,
  output logic [15:0]            out_ack_crc
);
  import swfr_pkg::*;

  logic        valid_r;
  logic        kind_r;
  logic [7:0]  payload_r;
  logic [2:0]  verdict_r;
  logic        ack_r;
  logic [7:0]  seq_r;
  logic [7:0]  window_r;
  logic [15:0] crc_r;
  logic        is_pay;

  assign pop    = !empty && (!valid_r || out_ready);
  assign is_pay = (head.kind == KIND_PAYLOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r    <= head.kind;
      payload_r <= is_pay ? head.data : 8'd0;
      verdict_r <= head.verdict;
      ack_r     <= head.ack;
      seq_r     <= head.ack ? head.data : 8'd0;
      window_r  <= head.ack ? cfg.ack_window : 8'd0;
      crc_r     <= head.ack ? crc16_byte(head.part_crc, cfg.ack_window) : 16'd0;
    end
  end

  assign out_valid          = valid_r;
  assign out_item_kind      = kind_r;
  assign out_payload_byte   = payload_r;
  assign out_verdict        = verdict_r;
  assign out_ack_valid      = ack_r;
  assign out_ack_seq        = seq_r;
  assign out_ack_window_out = window_r;
  assign out_ack_crc        = crc_r;

endmodule

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb - sliding_window_frame_receiver testbench
// Sends packets as a byte stream and predicts each payload beat and each
// verdict (with its acknowledgement fields and CRC) from a model of the
// receiver kept here. Register settings change between drained phases.
// Stimulus is a directed set of frames, then mostly well-formed random
// frames mixed with corrupted, reset, foreign and noise packets. Both sides
// stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swfr_pkg::*;

  localparam int unsigned MAX_LEN      = MAX_PACKET_LEN_DEF;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          STUCK_LIMIT  = 1000;
  localparam int          PHASE_BEATS  = 70;

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
  } tx_beat_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pbyte;
    logic [2:0]  verdict;
    logic        ack;
    logic [7:0]  ack_seq;
    logic [7:0]  ack_win;
    logic [15:0] ack_crc;
  } result_t;

  logic        clk               = 1'b0;
  logic        rst_n             = 1'b0;
  logic        psel              = 1'b0;
  logic        penable           = 1'b0;
  logic        pwrite            = 1'b0;
  logic [4:0]  paddr             = '0;
  logic [31:0] pwdata            = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid          = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte      = '0;
  logic        in_last_of_packet = 1'b0;
  logic        out_valid;
  logic        out_ready         = 1'b0;
  logic        out_item_kind;
  logic [7:0]  out_payload_byte;
  logic [2:0]  out_verdict;
  logic        out_ack_valid;
  logic [7:0]  out_ack_seq;
  logic [7:0]  out_ack_window_out;
  logic [15:0] out_ack_crc;

  sliding_window_frame_receiver u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_last_of_packet  (in_last_of_packet),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_item_kind      (out_item_kind),
    .out_payload_byte   (out_payload_byte),
    .out_verdict        (out_verdict),
    .out_ack_valid      (out_ack_valid),
    .out_ack_seq        (out_ack_seq),
    .out_ack_window_out (out_ack_window_out),
    .out_ack_crc        (out_ack_crc)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // register copies
  logic       cfg_link       = 1'b0;
  logic [7:0] cfg_data_type  = 8'h01;
  logic [7:0] cfg_reset_type = 8'h03;
  logic [7:0] cfg_ack_type   = 8'h02;
  logic [7:0] cfg_ack_window = 8'h08;

  // receiver state
  logic [7:0]  exp_seq  = '0;
  logic [15:0] at_pos   = '0;
  logic [7:0]  f_type   = '0;
  logic [7:0]  f_seq    = '0;
  logic [15:0] f_len    = '0;
  logic [15:0] run_crc  = CRC_INIT;
  logic [15:0] hdr_crc  = '0;
  logic [15:0] calc_crc = '0;
  logic [15:0] got_crc  = '0;

  tx_beat_t   tx_bytes[$];
  result_t    due_results[$];
  logic [7:0] pkt[$];

  logic       idle_on  = 1'b1;
  logic [7:0] tx_seq   = '0;
  int         tx_gap   = 0;
  int         rx_stall = 0;
  int         queued   = 0;
  int         errors   = 0;
  int         n_beats  = 0;
  int         n_packets = 0;
  int         n_payload = 0;
  int         n_phases = 0;
  int         vcnt[5];
  int         stuck    = 0;

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      if (c[15] ^ b[i]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic result_t verdict_item(logic [2:0] v, logic ack, logic [7:0] s);
    result_t r;
    r = '0;
    r.kind    = KIND_VERDICT;
    r.verdict = v;
    r.ack     = ack;
    if (ack) begin
      r.ack_seq = s;
      r.ack_win = cfg_ack_window;
      r.ack_crc = crc_step(crc_step(crc_step(CRC_INIT, cfg_ack_type), s), cfg_ack_window);
    end
    return r;
  endfunction

  // one accepted input beat -> zero or one expected result
  function automatic void frame_predict(logic [7:0] b, logic eop);
    int unsigned p, crc_end, total;
    logic        is_data, emit;
    result_t     r;
    p    = at_pos;
    emit = 1'b0;
    r    = '0;
    case (p)
      0: begin
        f_type  = b;
        hdr_crc = crc_step(CRC_INIT, b);
      end
      1: f_seq = b;
      2: f_len[7:0] = b;
      3: f_len[15:8] = b;
      default: ;
    endcase
    is_data = (f_type != cfg_reset_type) && (f_type == cfg_data_type);
    crc_end = 4 + f_len;
    // reset frames carry their check right after the type byte
    if (p == 1 && f_type == cfg_reset_type) got_crc[7:0] = b;
    else if (p == 2 && f_type == cfg_reset_type) got_crc[15:8] = b;
    if (p < 4 || p < crc_end) begin
      run_crc = crc_step(run_crc, b);
      if (p >= 4 && is_data && cfg_link) emit = 1'b1;
    end else if (p == crc_end) begin
      calc_crc = run_crc;
      if (f_type != cfg_reset_type) got_crc[7:0] = b;
    end else if (p == crc_end + 1) begin
      if (f_type != cfg_reset_type) got_crc[15:8] = b;
    end
    if (p == 3 && crc_end == 4) calc_crc = run_crc;

    if (!eop) begin
      if (at_pos != 16'hFFFF) at_pos++;
      if (emit) begin
        r.kind  = KIND_PAYLOAD;
        r.pbyte = b;
        due_results.push_back(r);
      end
      return;
    end

    total = p + 1;
    if (!cfg_link) begin
      r = verdict_item(VERDICT_IGNORED, 1'b0, 8'h00);
    end else if (f_type == cfg_reset_type) begin
      if (total > MAX_LEN || total < 3 || got_crc != hdr_crc) begin
        r = verdict_item(VERDICT_DROPPED, 1'b0, 8'h00);
      end else begin
        exp_seq = '0;
        r = verdict_item(VERDICT_RESET, 1'b0, 8'h00);
      end
    end else if (f_type != cfg_data_type) begin
      r = verdict_item(VERDICT_IGNORED, 1'b0, 8'h00);
    end else if (total > MAX_LEN || total < 7 || crc_end + 2 > total ||
                 got_crc != calc_crc) begin
      r = verdict_item(VERDICT_DROPPED, 1'b0, 8'h00);
    end else if (f_seq != exp_seq) begin
      r = verdict_item(VERDICT_OUT_ORDER, 1'b1, 8'(exp_seq - 8'd1));
    end else begin
      r = verdict_item(VERDICT_ACCEPTED, 1'b1, f_seq);
      exp_seq = 8'(exp_seq + 8'd1);
    end
    due_results.push_back(r);
    at_pos   = '0;
    f_type   = '0;
    f_seq    = '0;
    f_len    = '0;
    run_crc  = CRC_INIT;
    hdr_crc  = '0;
    calc_crc = '0;
    got_crc  = '0;
  endfunction

  function automatic int draw_wait();
    return idle_on ? int'($urandom_range(0, 7)) : 0;
  endfunction

  // input side
  always @(posedge clk) begin : tx_side
    logic fire;
    fire = in_valid && in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        frame_predict(in_data_byte, in_last_of_packet);
        void'(tx_bytes.pop_front());
        n_beats++;
        if (in_last_of_packet) n_packets++;
        tx_gap = draw_wait();
      end
      if (!in_valid || fire) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          in_valid          <= 1'b1;
          in_data_byte      <= tx_bytes[0].data;
          in_last_of_packet <= tx_bytes[0].eop;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // result side
  always @(posedge clk) begin : rx_side
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat: expected none, actual kind %0d byte %h verdict %0d",
                   $time, out_item_kind, out_payload_byte, out_verdict);
        end else begin
          want = due_results.pop_front();
          cmp_field("item_kind", 16'(want.kind), 16'(out_item_kind));
          cmp_field("payload_byte", 16'(want.pbyte), 16'(out_payload_byte));
          cmp_field("verdict", 16'(want.verdict), 16'(out_verdict));
          cmp_field("ack_valid", 16'(want.ack), 16'(out_ack_valid));
          cmp_field("ack_seq", 16'(want.ack_seq), 16'(out_ack_seq));
          cmp_field("ack_window_out", 16'(want.ack_win), 16'(out_ack_window_out));
          cmp_field("ack_crc", want.ack_crc, out_ack_crc);
          if (want.kind == KIND_PAYLOAD) n_payload++;
          else if (want.verdict <= VERDICT_IGNORED) vcnt[want.verdict]++;
        end
        rx_stall = draw_wait();
      end
      out_ready <= (rx_stall == 0);
      if (rx_stall > 0) rx_stall--;
    end
  end

  // watchdog: any handshake on either channel restarts the count
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("%0t: watchdog: no beat moved for %0d cycles", $time, STUCK_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LINK_ACTIVE: cfg_link       = val[0];
      REG_DATA_TYPE:   cfg_data_type  = val[7:0];
      REG_RESET_TYPE:  cfg_reset_type = val[7:0];
      REG_ACK_TYPE:    cfg_ack_type   = val[7:0];
      REG_ACK_WINDOW:  cfg_ack_window = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic link, logic [7:0] dt, logic [7:0] rt,
                            logic [7:0] at, logic [7:0] win);
    write_reg(REG_LINK_ACTIVE, {31'd0, link});
    write_reg(REG_DATA_TYPE, {24'd0, dt});
    write_reg(REG_RESET_TYPE, {24'd0, rt});
    write_reg(REG_ACK_TYPE, {24'd0, at});
    write_reg(REG_ACK_WINDOW, {24'd0, win});
    n_phases++;
    @(negedge clk);
  endtask

  // wait until every byte is in, every result is out, and the pipe is empty
  task automatic drain();
    @(negedge clk);
    while (tx_bytes.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [15:0] pkt_crc();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (pkt[i]) c = crc_step(c, pkt[i]);
    return c;
  endfunction

  task automatic add_noise(int unsigned k);
    repeat (k) pkt.push_back(8'($urandom));
  endtask

  task automatic build_data(logic [7:0] ft, logic [7:0] s, int unsigned n);
    logic [15:0] c;
    logic [15:0] len;
    len = n[15:0];
    pkt.delete();
    pkt.push_back(ft);
    pkt.push_back(s);
    pkt.push_back(len[7:0]);
    pkt.push_back(len[15:8]);
    add_noise(n);
    c = pkt_crc();
    pkt.push_back(c[7:0]);
    pkt.push_back(c[15:8]);
  endtask

  task automatic build_reset(logic [7:0] ft);
    logic [15:0] c;
    c = crc_step(CRC_INIT, ft);
    pkt.delete();
    pkt.push_back(ft);
    pkt.push_back(c[7:0]);
    pkt.push_back(c[15:8]);
  endtask

  // sender's own idea of the next sequence number
  task automatic note_data(logic [7:0] s);
    if (cfg_link && cfg_data_type != cfg_reset_type && s == tx_seq && pkt.size() <= MAX_LEN)
      tx_seq++;
  endtask

  task automatic ship();
    tx_beat_t bt;
    foreach (pkt[i]) begin
      bt.data = pkt[i];
      bt.eop  = (i == pkt.size() - 1);
      tx_bytes.push_back(bt);
    end
    queued += pkt.size();
    pkt.delete();
  endtask

  task automatic send_good(logic [7:0] s, int unsigned n);
    build_data(cfg_data_type, s, n);
    note_data(s);
    ship();
  endtask

  task automatic random_packet();
    int unsigned pick, n, k;
    logic [7:0]  s;
    pick = $urandom_range(0, 99);
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
    s = ($urandom_range(0, 9) < 8) ? tx_seq : 8'($urandom);
    if (pick < 55) begin
      build_data(cfg_data_type, s, n);
      if ($urandom_range(0, 9) == 0) add_noise($urandom_range(1, 4));
      note_data(s);
    end else if (pick < 67) begin
      build_data(cfg_data_type, s, n);
      case ($urandom_range(0, 3))
        0: begin
          k = $urandom_range(0, pkt.size() - 1);
          pkt[k] = pkt[k] ^ 8'(1 << $urandom_range(0, 7));
        end
        1: begin
          k = $urandom_range(1, pkt.size() - 1);
          while (pkt.size() > k) void'(pkt.pop_back());
        end
        2: pkt[2] = 8'(pkt[2] + 8'($urandom_range(1, 255)));
        default: void'(pkt.pop_back());
      endcase
    end else if (pick < 77) begin
      build_reset(cfg_reset_type);
      case ($urandom_range(0, 3))
        0: if (cfg_link) tx_seq = '0;
        1: begin
          add_noise($urandom_range(1, 5));
          if (cfg_link) tx_seq = '0;
        end
        2: pkt[1] = pkt[1] ^ 8'(1 << $urandom_range(0, 7));
        default: begin
          k = $urandom_range(1, 2);
          while (pkt.size() > k) void'(pkt.pop_back());
        end
      endcase
    end else if (pick < 88) begin
      pkt.delete();
      add_noise($urandom_range(1, 10));
    end else begin
      build_data(8'($urandom), s, n);
    end
    ship();
  endtask

  initial begin : stim
    logic [7:0] t;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // link down after reset: a clean data frame is only ignored
    build_data(cfg_data_type, 8'h00, 2);
    ship();
    drain();

    set_config(1'b1, 8'h01, 8'h03, 8'h02, 8'h08);
    send_good(tx_seq, 0);
    send_good(tx_seq, 3);
    build_data(cfg_data_type, tx_seq + 8'd5, 1);        // out of order
    ship();
    build_data(cfg_data_type, tx_seq, 2);               // bad CRC
    pkt[pkt.size() - 1] = pkt[pkt.size() - 1] ^ 8'h80;
    ship();
    build_data(cfg_data_type, tx_seq, 0);               // five bytes: too short
    void'(pkt.pop_back());
    ship();
    build_data(cfg_data_type, tx_seq, 5);               // truncated
    repeat (3) void'(pkt.pop_back());
    ship();
    build_data(cfg_data_type, tx_seq, 2);               // bytes after the CRC
    add_noise(3);
    note_data(tx_seq);
    ship();
    pkt.delete();                                       // length 0xFFFF, short packet
    pkt.push_back(cfg_data_type);
    pkt.push_back(tx_seq);
    pkt.push_back(8'hFF);
    pkt.push_back(8'hFF);
    add_noise(6);
    ship();
    build_reset(cfg_reset_type);
    tx_seq = '0;
    ship();
    build_data(cfg_data_type, 8'd9, 0);                 // re-ack wraps to 255
    ship();
    build_reset(cfg_reset_type);                        // reset with bad check
    pkt[2] = ~pkt[2];
    ship();
    build_reset(cfg_reset_type);                        // reset too short
    void'(pkt.pop_back());
    ship();
    build_reset(cfg_reset_type);                        // reset with trailing bytes
    add_noise(2);
    ship();
    build_data(8'h77, tx_seq, 1);                       // foreign type
    ship();
    pkt.push_back(cfg_data_type);                       // one-byte packets
    ship();
    pkt.push_back(8'h55);
    ship();
    build_data(cfg_data_type, tx_seq, MAX_LEN - 5);     // one over the limit
    ship();
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      t = 8'($urandom);
      case (ph)
        0: set_config(1'b1, 8'h01, 8'h03, 8'h02, 8'h08);
        1: set_config(1'b1, 8'h00, 8'hFF, 8'hFF, 8'h00);
        2: set_config(1'b1, 8'hFF, 8'h00, 8'h00, 8'hFF);
        3: set_config(1'b1, t, t, 8'($urandom), 8'($urandom));   // reset type wins
        4: set_config(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        default: set_config(1'b1, t, t ^ 8'($urandom_range(1, 255)), 8'($urandom),
                            8'($urandom));
      endcase
      idle_on = (ph % 3 != 1);
      queued = 0;
      while (queued < PHASE_BEATS) random_packet();
      drain();
    end

    $display("covered %0d bytes in %0d packets over %0d register settings",
             n_beats, n_packets, n_phases);
    $display("results: %0d payload, verdicts acc/ooo/rst/drop/ign %0d/%0d/%0d/%0d/%0d",
             n_payload, vcnt[0], vcnt[1], vcnt[2], vcnt[3], vcnt[4]);
    if (errors == 0 && due_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
